FILE: design/xtea_pkg.sv
// Shared types, constants and helpers for the XTEA cipher core.
`timescale 1ns / 1ps

package xtea_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E3779B9;

    // Key register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = 8'd3;

    // Key values after reset
    localparam logic [WORD_W-1:0] KEY_WORD0_RST = 32'd31231234;
    localparam logic [WORD_W-1:0] KEY_WORD1_RST = 32'd412334;
    localparam logic [WORD_W-1:0] KEY_WORD2_RST = 32'd12341;
    localparam logic [WORD_W-1:0] KEY_WORD3_RST = 32'd657657;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } t_xtea_req;

    typedef struct packed {
        logic [WORD_W-1:0] out_first_word;
        logic [WORD_W-1:0] out_second_word;
    } t_xtea_res;

    // Per-stage round constants, fixed at elaboration
    typedef struct packed {
        logic              upd_second;
        logic [WORD_W-1:0] enc_sum;
        logic [WORD_W-1:0] dec_sum;
    } t_xtea_stage_cfg;

    // XTEA word mixing: ((w << 4) ^ (w >> 5)) + w
    function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] w);
        return ((w << 4) ^ (w >> 5)) + w;
    endfunction

endpackage

FILE: design/xtea_stage.sv
// One registered XTEA half-round: updates one word of the block from the other.
`timescale 1ns / 1ps

module xtea_stage
    import xtea_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_xtea_stage_cfg     i_stage_cfg,
    input  logic [WORD_W-1:0]   i_enc_key,
    input  logic [WORD_W-1:0]   i_dec_key,
    input  logic                i_valid,
    input  t_xtea_req           i_data,
    output logic                o_valid,
    output t_xtea_req           o_data
);

    logic               r_valid;
    t_xtea_req          r_data;
    t_xtea_req          n_data;
    logic               upd_second;
    logic [WORD_W-1:0]  src_word;
    logic [WORD_W-1:0]  dst_word;
    logic [WORD_W-1:0]  round_sum;
    logic [WORD_W-1:0]  round_key;
    logic [WORD_W-1:0]  feistel;
    logic [WORD_W-1:0]  new_word;

    // Pick the word to update: encryption and decryption walk the halves in opposite order
    assign upd_second = i_stage_cfg.upd_second ^ i_data.cmd;
    assign src_word   = upd_second ? i_data.first_word  : i_data.second_word;
    assign dst_word   = upd_second ? i_data.second_word : i_data.first_word;
    assign round_sum  = (i_data.cmd == CMD_DECRYPT) ? i_stage_cfg.dec_sum : i_stage_cfg.enc_sum;
    assign round_key  = (i_data.cmd == CMD_DECRYPT) ? i_dec_key : i_enc_key;

    // Feistel function, then add on encryption and subtract on decryption
    assign feistel  = mix_word(src_word) ^ (round_sum + round_key);
    assign new_word = (i_data.cmd == CMD_DECRYPT) ? (dst_word - feistel)
                                                  : (dst_word + feistel);

    always_comb begin
        n_data = i_data;
        if (upd_second) begin
            n_data.second_word = new_word;
        end else begin
            n_data.first_word = new_word;
        end
    end

    // Advance the valid bit; clear it on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Hold the block payload
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/xtea_block_cipher_core.sv
// XTEA block cipher core: key registers and the unrolled half-round pipeline.
// Each accepted request travels through every half-round stage register to its result strobe.
// Throughput: one block per cycle; each half-round has its own register stage.
// busy stays low: the pipeline never stalls; the receiver must take every result, which the core does not enforce.
// Reset (synchronous, active low) clears all valid bits and loads the default key.
`timescale 1ns / 1ps

module xtea_block_cipher_core
    import xtea_pkg::*;
#(
    parameter int unsigned ROUNDS = 32
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_xtea_req             i_req,
    output logic                  o_result_valid,
    output t_xtea_res             o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [WORD_W-1:0]     i_cfg_data
);

    localparam int unsigned STAGES = 2 * ROUNDS;

    logic [WORD_W-1:0] r_key [4];
    logic              stg_valid [STAGES+1];
    t_xtea_req         stg_data  [STAGES+1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Take key writes; ignore indexes beyond the key words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= KEY_WORD0_RST;
            r_key[1] <= KEY_WORD1_RST;
            r_key[2] <= KEY_WORD2_RST;
            r_key[3] <= KEY_WORD3_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEY_WORD0: r_key[0] <= i_cfg_data;
                CFG_KEY_WORD1: r_key[1] <= i_cfg_data;
                CFG_KEY_WORD2: r_key[2] <= i_cfg_data;
                CFG_KEY_WORD3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign stg_valid[0] = start && !busy;
    assign stg_data[0]  = i_req;

    // Unroll the rounds: even stages take the first half-round, odd stages the second
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam int unsigned RND = k / 2;
        localparam bit          ODD = (k % 2) == 1;
        localparam logic [WORD_W-1:0] ENC_SUM =
            WORD_W'(64'(XTEA_DELTA) * 64'(ODD ? RND + 1 : RND));
        localparam logic [WORD_W-1:0] DEC_SUM =
            WORD_W'(64'(XTEA_DELTA) * 64'(ODD ? ROUNDS - RND - 1 : ROUNDS - RND));
        // First-word updates key on the low sum bits, second-word updates on bits 12:11
        localparam logic [1:0] ENC_KI = ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
        localparam logic [1:0] DEC_KI = ODD ? DEC_SUM[1:0]   : DEC_SUM[12:11];

        t_xtea_stage_cfg stage_cfg;
        assign stage_cfg.upd_second = ODD;
        assign stage_cfg.enc_sum    = ENC_SUM;
        assign stage_cfg.dec_sum    = DEC_SUM;

        xtea_stage u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_stage_cfg (stage_cfg),
            .i_enc_key   (r_key[ENC_KI]),
            .i_dec_key   (r_key[DEC_KI]),
            .i_valid     (stg_valid[k]),
            .i_data      (stg_data[k]),
            .o_valid     (stg_valid[k+1]),
            .o_data      (stg_data[k+1])
        );
    end

    // Drive the result from the last stage register
    assign o_result_valid           = stg_valid[STAGES];
    assign o_result.out_first_word  = stg_data[STAGES].first_word;
    assign o_result.out_second_word = stg_data[STAGES].second_word;

    // A result strobe only follows a request taken exactly one pipeline depth earlier
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, STAGES))
        else $error("result strobe without a matching request");

    // A request taken is delivered after the pipeline depth
    a_request_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##STAGES o_result_valid)
        else $error("request lost in the pipeline");

    // Keys hold unless a write handshake completes
    a_key_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_valid && o_cfg_ready) |=>
            ($stable(r_key[0]) && $stable(r_key[1]) && $stable(r_key[2]) && $stable(r_key[3])))
        else $error("key changed without a write");

    // A write to an index past the key words changes nothing
    a_key_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && (i_cfg_index > CFG_KEY_WORD3)) |=>
            ($stable(r_key[0]) && $stable(r_key[1]) && $stable(r_key[2]) && $stable(r_key[3])))
        else $error("out-of-range write changed a key");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the XTEA cipher core: keyed block encryption and decryption.
`timescale 1ns / 1ps

module testbench
    import xtea_pkg::*;
();

    localparam int unsigned ROUND_COUNT  = 32;
    localparam int unsigned LIMIT_CYCLES = 400000;

    // Track the expected ciphered blocks and compare each result strobe against them
    class block_scoreboard;
        logic [WORD_W-1:0] key_words [4];
        t_xtea_res         expected_blocks [$];
        int unsigned       round_total;
        int unsigned       error_count;
        int unsigned       compared_count;

        function new(int unsigned rounds);
            round_total    = rounds;
            error_count    = 0;
            compared_count = 0;
            key_words[0]   = KEY_WORD0_RST;
            key_words[1]   = KEY_WORD1_RST;
            key_words[2]   = KEY_WORD2_RST;
            key_words[3]   = KEY_WORD3_RST;
        endfunction

        // Indexes above the last key word leave the key untouched
        function void load_key(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            if (idx <= CFG_KEY_WORD3)
                key_words[idx[1:0]] = data;
        endfunction

        function logic [WORD_W-1:0] scramble(logic [WORD_W-1:0] w);
            logic [WORD_W-1:0] shifted;
            shifted = (w << 4) ^ (w >> 5);
            return shifted + w;
        endfunction

        // Run the full round schedule forwards or backwards on one block
        function t_xtea_res encipher_block(t_xtea_req req);
            logic [WORD_W-1:0] x;
            logic [WORD_W-1:0] y;
            logic [WORD_W-1:0] s;
            t_xtea_res         res;
            x = req.first_word;
            y = req.second_word;
            if (req.cmd == CMD_ENCRYPT) begin
                s = '0;
                for (int unsigned r = 0; r < round_total; r++) begin
                    x = x + (scramble(y) ^ (s + key_words[s[1:0]]));
                    s = s + XTEA_DELTA;
                    y = y + (scramble(x) ^ (s + key_words[s[12:11]]));
                end
            end else begin
                s = XTEA_DELTA * round_total;
                for (int unsigned r = 0; r < round_total; r++) begin
                    y = y - (scramble(x) ^ (s + key_words[s[12:11]]));
                    s = s - XTEA_DELTA;
                    x = x - (scramble(y) ^ (s + key_words[s[1:0]]));
                end
            end
            res.out_first_word  = x;
            res.out_second_word = y;
            return res;
        endfunction

        function void note_request(t_xtea_req req);
            expected_blocks.push_back(encipher_block(req));
        endfunction

        function void check_result(t_xtea_res got);
            t_xtea_res want;
            if (expected_blocks.size() == 0) begin
                $error("unexpected result: out_first_word %h out_second_word %h",
                       got.out_first_word, got.out_second_word);
                error_count++;
                return;
            end
            want = expected_blocks.pop_front();
            compared_count++;
            if (got.out_first_word !== want.out_first_word) begin
                $error("out_first_word: expected %h, actual %h",
                       want.out_first_word, got.out_first_word);
                error_count++;
            end
            if (got.out_second_word !== want.out_second_word) begin
                $error("out_second_word: expected %h, actual %h",
                       want.out_second_word, got.out_second_word);
                error_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_blocks.size();
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_xtea_req            i_req       = '0;
    logic                 o_result_valid;
    t_xtea_res            o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data  = '0;

    block_scoreboard sb = new(ROUND_COUNT);

    int unsigned cycle_count   = 0;
    int unsigned encrypt_count = 0;
    int unsigned decrypt_count = 0;
    int unsigned key_settings  = 1;
    bit          idle_on       = 1'b1;

    xtea_block_cipher_core #(
        .ROUNDS(ROUND_COUNT)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abandon the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Check result strobes and record accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid)
                sb.check_result(o_result);
            if (start && !busy) begin
                sb.note_request(i_req);
                if (i_req.cmd == CMD_DECRYPT)
                    decrypt_count++;
                else
                    encrypt_count++;
            end
        end
    end

    // Bias towards the extremes and single-bit words now and then
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(WORD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_block(input t_xtea_req req);
        // Idle each cycle at random before presenting the request
        while (idle_on && $urandom_range(99) < 38) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic cmd, input logic [WORD_W-1:0] a,
                               input logic [WORD_W-1:0] b);
        t_xtea_req req;
        req.cmd         = cmd;
        req.first_word  = a;
        req.second_word = b;
        send_block(req);
    endtask

    // Hold off new requests until every expected result has arrived
    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.load_key(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_full_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                                 input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
        cfg_write(CFG_KEY_WORD0, k0);
        cfg_write(CFG_KEY_WORD1, k1);
        cfg_write(CFG_KEY_WORD2, k2);
        cfg_write(CFG_KEY_WORD3, k3);
        key_settings++;
    endtask

    // Random blocks under the current key, with an optional mid-phase drain
    task automatic run_random_blocks(input int unsigned count, input int unsigned pause_at);
        for (int unsigned i = 0; i < count; i++) begin
            send_fields(1'($urandom_range(1)), pick_word(), pick_word());
            if (i == pause_at)
                drain_results();
        end
        drain_results();
    endtask

    initial begin
        t_xtea_req probe;
        t_xtea_res cipher;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed blocks under the reset key
        send_fields(CMD_ENCRYPT, '0, '0);
        send_fields(CMD_DECRYPT, '0, '0);
        send_fields(CMD_ENCRYPT, '1, '1);
        send_fields(CMD_DECRYPT, '1, '1);
        send_fields(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_fields(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        send_fields(CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_fields(CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
        send_fields(CMD_ENCRYPT, '0, '1);
        send_fields(CMD_DECRYPT, '1, '0);

        // Feed a ciphertext back in for decryption
        probe.cmd         = CMD_ENCRYPT;
        probe.first_word  = 32'h0123_4567;
        probe.second_word = 32'h89AB_CDEF;
        send_block(probe);
        cipher            = sb.encipher_block(probe);
        probe.cmd         = CMD_DECRYPT;
        probe.first_word  = cipher.out_first_word;
        probe.second_word = cipher.out_second_word;
        send_block(probe);
        drain_results();

        // Writes beyond the last key word must leave the key alone
        cfg_write(CFG_KEY_WORD3 + 8'd1, '1);
        cfg_write('1, 32'hDEAD_BEEF);
        send_fields(CMD_ENCRYPT, 32'h0000_FFFF, 32'hFFFF_0000);
        send_fields(CMD_DECRYPT, 32'hFFFF_0000, 32'h0000_FFFF);
        drain_results();

        load_full_key('0, '0, '0, '0);
        run_random_blocks(300, 0);

        // Long stretch with no idling at all
        idle_on = 1'b0;
        load_full_key('1, '1, '1, '1);
        run_random_blocks(300, 0);
        idle_on = 1'b1;

        load_full_key('1, '0, 32'h8000_0000, 32'h0000_0001);
        run_random_blocks(400, 200);

        load_full_key($urandom, $urandom, $urandom, $urandom);
        run_random_blocks(500, 0);

        load_full_key($urandom, $urandom, $urandom, $urandom);
        run_random_blocks(500, 0);

        // Allow the pipeline to flush any stray strobes
        repeat (2 * ROUND_COUNT + 16) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.error_count++;
        end

        $display("Run covered %0d encryptions and %0d decryptions under %0d key settings,",
                 encrypt_count, decrypt_count, key_settings);
        $display("including ignored out-of-range key writes; %0d results compared.",
                 sb.compared_count);
        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
